// File: rtl/core/lrupbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupbm_pkg
// Shared types and constants for the LRU page buffer manager.
// ----------------------------------------------------------------------------
package lrupbm_pkg;

  // Default size of the frame pool.
  localparam int FRAME_COUNT_DEF = 16;

  // Field widths.
  localparam int FILE_W  = 16;
  localparam int PAGE_W  = 16;
  localparam int TAG_W   = FILE_W + PAGE_W;
  localparam int ACT_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int IN_DW   = 32;
  localparam int OUT_DW  = 40;

  // Result action codes.
  localparam logic [ACT_W-1:0] ACT_HIT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WB   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the request tag
    logic hit;       // emit hit result and make the hit slot most recent
    logic fill;      // take the next unused slot and emit a load
    logic wb;        // emit write-back of the LRU frame, latch victim slot
    logic load;      // reuse the victim slot and emit a load
  } lrupbm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // request tag found in a valid slot
    logic full;      // every slot is in use
    logic out_free;  // output register can take a result this cycle
  } lrupbm_sts_t;

endpackage

// File: rtl/core/lru_page_buffer_manager_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_buffer_manager_top
// Fully associative page frame manager with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one request item per page lookup: file id in
//   in_tdata[15:0], page number in in_tdata[31:16]. Each request yields one
//   or two items on the output stream: a hit, a load into a free slot, or a
//   write-back of the oldest frame followed by a load into that slot.
//   out_tlast marks the final item of a request; out_tuser is the action.
//   Timing: a request is taken in the idle state and looked up in the lookup
//   state once the output register is free; a write-back adds a second item.
//   The recency update of the single rank table must finish before the next
//   lookup; no new request is taken until the last one's items are issued.
//   The request tag is registered on accept; the lookup fills the output register.
//   A result waiting in the output register does not block the next request
//   from being accepted; its lookup then waits until the register frees.
//   When the receiver stalls, the output item holds and the block stops.
//   Reset empties the pool (all slots unused, ranks zero); no clearing pass.
// ----------------------------------------------------------------------------
module lru_page_buffer_manager_top #(
  parameter int FRAME_COUNT = lrupbm_pkg::FRAME_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [15:0] req_file, [31:16] req_page
  input  logic [lrupbm_pkg::IN_DW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [3:0] frame_slot, [19:4] page_file, [35:20] page_number, [39:36] zero
  output logic [lrupbm_pkg::OUT_DW-1:0] out_tdata,
  // [1:0] action
  output logic [lrupbm_pkg::ACT_W-1:0]  out_tuser,
  output logic                          out_tlast
);
  import lrupbm_pkg::*;

  lrupbm_cmd_t       cmd;
  lrupbm_sts_t       sts;
  logic [SLOT_W-1:0] out_slot;
  logic [FILE_W-1:0] out_file;
  logic [PAGE_W-1:0] out_page;

  // Controller.
  lrupbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  lrupbm_dp #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_file   (in_tdata[FILE_W-1:0]),
    .req_page   (in_tdata[FILE_W+PAGE_W-1:FILE_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_action (out_tuser),
    .out_slot   (out_slot),
    .out_file   (out_file),
    .out_page   (out_page),
    .out_last   (out_tlast)
  );

  // Pack the result payload, padded to whole bytes.
  assign out_tdata = {4'b0000, out_page, out_file, out_slot};

endmodule

// File: rtl/core/lrupbm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupbm_dp
// Datapath: tag store with parallel lookup, recency ranks, fill count,
// victim selection and the result register.
// ----------------------------------------------------------------------------
module lrupbm_dp #(
  parameter int FRAME_COUNT = lrupbm_pkg::FRAME_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lrupbm_pkg::FILE_W-1:0] req_file,
  input  logic [lrupbm_pkg::PAGE_W-1:0] req_page,
  input  lrupbm_pkg::lrupbm_cmd_t       cmd,
  output lrupbm_pkg::lrupbm_sts_t       sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [lrupbm_pkg::ACT_W-1:0]  out_action,
  output logic [lrupbm_pkg::SLOT_W-1:0] out_slot,
  output logic [lrupbm_pkg::FILE_W-1:0] out_file,
  output logic [lrupbm_pkg::PAGE_W-1:0] out_page,
  output logic                          out_last
);
  import lrupbm_pkg::*;

  localparam int SW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CW = $clog2(FRAME_COUNT + 1);
  localparam logic [SW-1:0] AGE_MAX = SW'(FRAME_COUNT - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(FRAME_COUNT);

  logic [TAG_W-1:0]       req_tag_r;
  logic [TAG_W-1:0]       tag_r [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] valid_r;
  logic [SW-1:0]          age_r [FRAME_COUNT];
  logic [CW-1:0]          used_r;
  logic [SW-1:0]          vic_r;

  logic                   out_valid_r;
  logic [ACT_W-1:0]       out_action_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [FILE_W-1:0]      out_file_r;
  logic [PAGE_W-1:0]      out_page_r;
  logic                   out_last_r;

  logic [FRAME_COUNT-1:0] match;
  logic [SW-1:0]          hit_idx;
  logic [SW-1:0]          lru_idx;
  logic [SW-1:0]          fill_idx;
  logic [SW-1:0]          hit_age;
  logic                   full;
  logic                   out_free;

  // Parallel tag compare; the lowest matching index wins.
  always_comb begin
    hit_idx = '0;
    lru_idx = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (tag_r[i] == req_tag_r);
      if (match[i]) begin
        hit_idx = SW'(i);
      end
      // With a full pool the ranks are distinct, so exactly one slot is oldest.
      if (valid_r[i] && (age_r[i] == AGE_MAX)) begin
        lru_idx = SW'(i);
      end
    end
  end

  assign hit_age  = age_r[hit_idx];
  assign full     = (used_r == CNT_FULL);
  assign fill_idx = used_r[SW-1:0];
  assign out_free = !out_valid_r || out_ready;

  assign sts.hit      = |match;
  assign sts.full     = full;
  assign sts.out_free = out_free;

  // Slot index widened or cut to the four-bit result field.
  function automatic logic [SLOT_W-1:0] slot_field(input logic [SW-1:0] idx);
    logic [SW+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

  // Request tag and tag store; contents are meaningful only where valid.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_tag_r <= {req_file, req_page};
    end
    if (cmd.fill) begin
      tag_r[fill_idx] <= req_tag_r;
    end
    if (cmd.load) begin
      tag_r[vic_r] <= req_tag_r;
    end
    if (cmd.wb) begin
      vic_r <= lru_idx;
    end
  end

  // Valid bits, recency ranks and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      if (cmd.hit) begin
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if ((SW'(i) != hit_idx) && valid_r[i] && (age_r[i] < hit_age)) begin
            age_r[i] <= age_r[i] + SW'(1);
          end
        end
        age_r[hit_idx] <= '0;
      end
      if (cmd.fill) begin
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if (valid_r[i]) begin
            age_r[i] <= age_r[i] + SW'(1);
          end
        end
        age_r[fill_idx]   <= '0;
        valid_r[fill_idx] <= 1'b1;
        used_r            <= used_r + CW'(1);
      end
      // The victim holds the oldest rank, so every other slot ages by one.
      if (cmd.load) begin
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if (SW'(i) != vic_r) begin
            age_r[i] <= age_r[i] + SW'(1);
          end
        end
        age_r[vic_r] <= '0;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.hit || cmd.fill || cmd.wb || cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.hit) begin
      out_action_r <= ACT_HIT;
      out_slot_r   <= slot_field(hit_idx);
      out_file_r   <= req_tag_r[TAG_W-1:PAGE_W];
      out_page_r   <= req_tag_r[PAGE_W-1:0];
      out_last_r   <= 1'b1;
    end else if (cmd.fill) begin
      out_action_r <= ACT_LOAD;
      out_slot_r   <= slot_field(fill_idx);
      out_file_r   <= req_tag_r[TAG_W-1:PAGE_W];
      out_page_r   <= req_tag_r[PAGE_W-1:0];
      out_last_r   <= 1'b1;
    end else if (cmd.wb) begin
      out_action_r <= ACT_WB;
      out_slot_r   <= slot_field(lru_idx);
      out_file_r   <= tag_r[lru_idx][TAG_W-1:PAGE_W];
      out_page_r   <= tag_r[lru_idx][PAGE_W-1:0];
      out_last_r   <= 1'b0;
    end else if (cmd.load) begin
      out_action_r <= ACT_LOAD;
      out_slot_r   <= slot_field(vic_r);
      out_file_r   <= req_tag_r[TAG_W-1:PAGE_W];
      out_page_r   <= req_tag_r[PAGE_W-1:0];
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;
  assign out_slot   = out_slot_r;
  assign out_file   = out_file_r;
  assign out_page   = out_page_r;
  assign out_last   = out_last_r;

endmodule

// File: rtl/core/lrupbm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupbm_ctrl
// Controller: sequences request capture, lookup and the one or two results.
// ----------------------------------------------------------------------------
module lrupbm_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  lrupbm_pkg::lrupbm_sts_t sts,
  output lrupbm_pkg::lrupbm_cmd_t cmd
);
  import lrupbm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (sts.out_free) begin
          if (sts.hit) begin
            cmd.hit   = 1'b1;
            state_nxt = ST_IDLE;
          end else if (!sts.full) begin
            cmd.fill  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.wb    = 1'b1;
            state_nxt = ST_WB;
          end
        end
      end
      ST_WB: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
